@@ sv/tsam_pkg.sv @@
`timescale 1ns / 1ps
// tsam_pkg: shared types and constants of the touch sample averager.
// No dependencies; used by the config bank, the divider and the top level.
package tsam_pkg;

    localparam int RAW_W   = 16;           // raw sample and window width
    localparam int SUM_W   = 19;           // accumulator width
    localparam int CNT_W   = 3;            // sample counter width
    localparam int SCR_W   = 10;           // screen coordinate and scale width
    localparam int CIDX_W  = 3;            // config register index width
    localparam int DIV_AW  = RAW_W + SCR_W; // dividend width of the shared divider
    localparam int DIV_BW  = RAW_W;         // divisor width of the shared divider

    // config register indexes
    localparam logic [CIDX_W-1:0] REG_X_LOW   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_X_HIGH  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_Y_LOW   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_Y_HIGH  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_SCALE_Y = 3'd4;
    localparam logic [CIDX_W-1:0] REG_SCALE_X = 3'd5;
    localparam logic [CIDX_W-1:0] REG_ORIENT  = 3'd6;

    // orientation codes
    localparam logic [1:0] ORIENT_LAND     = 2'd0;
    localparam logic [1:0] ORIENT_PORT     = 2'd1;
    localparam logic [1:0] ORIENT_PORT_MIR = 2'd2;
    localparam logic [1:0] ORIENT_LAND_MIR = 2'd3;

    typedef struct packed {
        logic [RAW_W-1:0] x_low;
        logic [RAW_W-1:0] x_high;
        logic [RAW_W-1:0] y_low;
        logic [RAW_W-1:0] y_high;
        logic [SCR_W-1:0] scale_y;   // applied to the X axis value
        logic [SCR_W-1:0] scale_x;   // applied to the Y axis value
        logic [1:0]       orient;
    } t_cfg;

    // a - b, floored at zero
    function automatic logic [SCR_W-1:0] sub_sat(input logic [SCR_W-1:0] a,
                                                 input logic [SCR_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

@@ sv/tsam_smp_if.sv @@
`timescale 1ns / 1ps
// tsam_smp_if: valid/ready channel carrying one raw X/Y sample pair.
// Depends on nothing.
interface tsam_smp_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_x;
    logic [15:0] sample_y;

    modport source (output valid, output sample_x, output sample_y, input ready);
    modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

@@ sv/tsam_pos_if.sv @@
`timescale 1ns / 1ps
// tsam_pos_if: valid/ready channel carrying one screen coordinate pair.
// Depends on nothing.
interface tsam_pos_if;
    logic       valid;
    logic       ready;
    logic [9:0] screen_x;
    logic [9:0] screen_y;

    modport source (output valid, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

@@ sv/touch_sample_average_and_map.sv @@
`timescale 1ns / 1ps
// touch_sample_average_and_map: averages raw touch pairs and maps them to screen.
// Depends on tsam_pkg, tsam_smp_if, tsam_pos_if, tsam_cfg and tsam_div.
//
//  channel   dir  transfer when          payload
//  i_smp     in   valid & ready          sample_x[15:0], sample_y[15:0]
//  o_pos     out  valid & ready          screen_x[9:0],  screen_y[9:0]
//  i_cfg_*   in   i_cfg_we high          i_cfg_idx[2:0], i_cfg_data[15:0]
//
// Sample pairs that do not complete a group are taken back to back.
// The pair that completes the group starts the sequencer: two averages on the shared
// multiplier (reciprocal of the count), then per axis clamp/diff/multiply
// and one serial divide by the span (skipped on a zero span), then one mapping
// step: i_smp is not ready from that transfer until the mapping step is done.
// Synchronous active-low reset clears sums, counter,
// sequencer and output valid. A stalled o_pos holds its coordinate; new samples are
// still taken meanwhile, only the final mapping step waits for the output register.
module touch_sample_average_and_map #(
    parameter int SAMPLE_COUNT  = 5,
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tsam_smp_if.sink                     i_smp,
    tsam_pos_if.source                   o_pos,
    input  logic                         i_cfg_we,
    input  logic [tsam_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [tsam_pkg::RAW_W-1:0]   i_cfg_data
);
    import tsam_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;  // accumulating samples
    localparam logic [3:0] ST_AVGX  = 4'd1;  // sum_x times reciprocal of the count
    localparam logic [3:0] ST_AVGY  = 4'd2;  // sum_y times reciprocal of the count
    localparam logic [3:0] ST_CLAMP = 4'd3;  // clamp average into window, span
    localparam logic [3:0] ST_DIFF  = 4'd4;  // offset from low
    localparam logic [3:0] ST_MUL   = 4'd5;  // offset * full scale, launch divide
    localparam logic [3:0] ST_SCALE = 4'd6;  // dividing by the span
    localparam logic [3:0] ST_MAP   = 4'd7;  // orientation mapping to output

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_COUNT);
    localparam logic [SCR_W-1:0] SCR_WID  = SCR_W'(SCREEN_WIDTH);
    localparam logic [SCR_W-1:0] SCR_HGT  = SCR_W'(SCREEN_HEIGHT);

    // sum / count as (sum * ceil(2^K / count)) >> K, exact for any 19-bit sum
    localparam int RCP_L = $clog2(SAMPLE_COUNT);
    localparam int RCP_K = SUM_W + RCP_L;
    localparam int RCP_W = SUM_W + 2;
    localparam int MUL_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_K) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    t_cfg cfg;

    tsam_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    logic              div_done;
    logic [DIV_AW-1:0] div_quot;

    logic [3:0]        r_state, n_state;
    logic [SUM_W-1:0]  r_sum_x, n_sum_x;
    logic [SUM_W-1:0]  r_sum_y, n_sum_y;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_axis, n_axis;        // 0: X axis value, 1: Y axis value
    logic [SUM_W-1:0]  r_avg_x, n_avg_x;
    logic [SUM_W-1:0]  r_avg_y, n_avg_y;
    logic [RAW_W-1:0]  r_clamp, n_clamp;
    logic [RAW_W-1:0]  r_diff, n_diff;
    logic [RAW_W-1:0]  r_span, n_span;
    logic [SCR_W-1:0]  r_tx, n_tx;
    logic [SCR_W-1:0]  r_ty, n_ty;
    logic              r_div_start, n_div_start;
    logic [DIV_AW-1:0] r_div_a, n_div_a;
    logic [DIV_BW-1:0] r_div_b, n_div_b;
    logic              r_out_valid, n_out_valid;
    logic [SCR_W-1:0]  r_out_x, n_out_x;
    logic [SCR_W-1:0]  r_out_y, n_out_y;

    tsam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // per-axis operand selection
    logic [SUM_W-1:0]  ax_avg;
    logic [RAW_W-1:0]  ax_lo, ax_hi;
    logic [SCR_W-1:0]  ax_full;
    logic [SUM_W-1:0]  clamp_lo;
    logic              accept;
    logic [SUM_W-1:0]  add_x, add_y;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SCR_W-1:0]  map_x, map_y;
    // shared multiplier: averages, then offset * full scale
    logic [SUM_W-1:0]  mul_a;
    logic [RCP_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;

    assign accept = i_smp.valid && i_smp.ready;

    always_comb begin
        ax_avg  = r_axis ? r_avg_y : r_avg_x;
        ax_lo   = r_axis ? cfg.y_low : cfg.x_low;
        ax_hi   = r_axis ? cfg.y_high : cfg.x_high;
        ax_full = r_axis ? cfg.scale_x : cfg.scale_y;

        // raise to low first, then lower to high (inverted window ends at high)
        clamp_lo = (ax_avg < {{(SUM_W-RAW_W){1'b0}}, ax_lo})
                   ? {{(SUM_W-RAW_W){1'b0}}, ax_lo} : ax_avg;

        add_x   = r_sum_x + {{(SUM_W-RAW_W){1'b0}}, i_smp.sample_x};
        add_y   = r_sum_y + {{(SUM_W-RAW_W){1'b0}}, i_smp.sample_y};
        cnt_inc = r_cnt + 1'b1;

        case (r_state)
            ST_AVGX: begin
                mul_a = r_sum_x;
                mul_b = RCP;
            end
            ST_AVGY: begin
                mul_a = r_sum_y;
                mul_b = RCP;
            end
            default: begin
                mul_a = {{(SUM_W-RAW_W){1'b0}}, r_diff};
                mul_b = {{(RCP_W-SCR_W){1'b0}}, ax_full};
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

        case (cfg.orient)
            ORIENT_LAND: begin
                map_x = r_ty;
                map_y = sub_sat(SCR_HGT, r_tx);
            end
            ORIENT_PORT: begin
                map_x = r_tx;
                map_y = r_ty;
            end
            ORIENT_PORT_MIR: begin
                map_x = sub_sat(SCR_WID, r_tx);
                map_y = sub_sat(SCR_HGT, r_ty);
            end
            default: begin
                map_x = sub_sat(SCR_HGT, r_ty);
                map_y = r_tx;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_avg_x     = r_avg_x;
        n_avg_y     = r_avg_y;
        n_clamp     = r_clamp;
        n_diff      = r_diff;
        n_span      = r_span;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_div_start = 1'b0;
        n_div_a     = r_div_a;
        n_div_b     = r_div_b;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_valid = r_out_valid && !o_pos.ready;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_sum_x = add_x;
                    n_sum_y = add_y;
                    n_cnt   = cnt_inc;
                    if (cnt_inc == LAST_CNT) begin
                        // group complete: average X first
                        n_cnt   = '0;
                        n_state = ST_AVGX;
                    end
                end
            end
            ST_AVGX: begin
                // average never exceeds a raw sample, 16 bits hold it
                n_avg_x = {{(SUM_W-RAW_W){1'b0}}, mul_p[RCP_K +: RAW_W]};
                n_sum_x = '0;
                n_state = ST_AVGY;
            end
            ST_AVGY: begin
                n_avg_y = {{(SUM_W-RAW_W){1'b0}}, mul_p[RCP_K +: RAW_W]};
                n_sum_y = '0;
                n_axis  = 1'b0;
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_clamp = (clamp_lo > {{(SUM_W-RAW_W){1'b0}}, ax_hi})
                          ? ax_hi : clamp_lo[RAW_W-1:0];
                n_span  = (ax_hi > ax_lo) ? (ax_hi - ax_lo) : '0;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_diff  = (r_clamp > ax_lo) ? (r_clamp - ax_lo) : '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_span == '0) begin
                    // empty window scales to zero, no divide
                    if (r_axis) begin
                        n_ty    = '0;
                        n_state = ST_MAP;
                    end else begin
                        n_tx    = '0;
                        n_axis  = 1'b1;
                        n_state = ST_CLAMP;
                    end
                end else begin
                    // offset * full scale < 2^26
                    n_div_a     = mul_p[DIV_AW-1:0];
                    n_div_b     = r_span;
                    n_div_start = 1'b1;
                    n_state     = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    // offset never exceeds span, so quotient <= full scale
                    if (r_axis) begin
                        n_ty    = div_quot[SCR_W-1:0];
                        n_state = ST_MAP;
                    end else begin
                        n_tx    = div_quot[SCR_W-1:0];
                        n_axis  = 1'b1;
                        n_state = ST_CLAMP;
                    end
                end
            end
            ST_MAP: begin
                if (!r_out_valid || o_pos.ready) begin
                    n_out_x     = map_x;
                    n_out_y     = map_y;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_avg_x <= n_avg_x;
        r_avg_y <= n_avg_y;
        r_clamp <= n_clamp;
        r_diff  <= n_diff;
        r_span  <= n_span;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_div_a <= n_div_a;
        r_div_b <= n_div_b;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign i_smp.ready    = (r_state == ST_IDLE);
    assign o_pos.valid    = r_out_valid;
    assign o_pos.screen_x = r_out_x;
    assign o_pos.screen_y = r_out_y;

endmodule

@@ sv/tsam_cfg.sv @@
`timescale 1ns / 1ps
// tsam_cfg: calibration and orientation register bank, write-only.
// Depends on tsam_pkg.
module tsam_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [tsam_pkg::CIDX_W-1:0] i_idx,
    input  logic [tsam_pkg::RAW_W-1:0]  i_data,
    output tsam_pkg::t_cfg             o_cfg
);
    import tsam_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                REG_X_LOW:   n_cfg.x_low   = i_data;
                REG_X_HIGH:  n_cfg.x_high  = i_data;
                REG_Y_LOW:   n_cfg.y_low   = i_data;
                REG_Y_HIGH:  n_cfg.y_high  = i_data;
                REG_SCALE_Y: n_cfg.scale_y = i_data[SCR_W-1:0];
                REG_SCALE_X: n_cfg.scale_x = i_data[SCR_W-1:0];
                REG_ORIENT:  n_cfg.orient  = i_data[1:0];
                default:     n_cfg = r_cfg;   // unused index: dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_low   <= '0;
            r_cfg.x_high  <= '1;
            r_cfg.y_low   <= '0;
            r_cfg.y_high  <= '1;
            r_cfg.scale_y <= SCR_W'(480);
            r_cfg.scale_x <= SCR_W'(320);
            r_cfg.orient  <= ORIENT_LAND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/tsam_div.sv @@
`timescale 1ns / 1ps
// tsam_div: restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on tsam_pkg. Divisor must be non-zero.
module tsam_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsam_pkg::DIV_AW-1:0] i_dividend,
    input  logic [tsam_pkg::DIV_BW-1:0] i_divisor,
    output logic                        o_done,
    output logic [tsam_pkg::DIV_AW-1:0] o_quot
);
    import tsam_pkg::*;

    localparam int CW = $clog2(DIV_AW);
    localparam logic [CW-1:0] LAST = CW'(DIV_AW - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_AW-1:0] r_quo, n_quo;
    logic [DIV_BW-1:0] r_rem, n_rem;
    logic [DIV_BW-1:0] r_dvs, n_dvs;

    logic [DIV_BW:0]   rem_sh;
    logic [DIV_BW:0]   rem_diff;
    logic              ge;

    always_comb begin
        rem_sh   = {r_rem, r_quo[DIV_AW-1]};
        rem_diff = rem_sh - {1'b0, r_dvs};
        ge       = (rem_sh >= {1'b0, r_dvs});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 16 bits hold it
            n_rem = ge ? rem_diff[DIV_BW-1:0] : rem_sh[DIV_BW-1:0];
            n_quo = {r_quo[DIV_AW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for touch_sample_average_and_map.
// Depends on tsam_pkg, tsam_smp_if, tsam_pos_if and the top level of the block.
module testbench;
    import tsam_pkg::*;

    localparam int SAMPLE_COUNT  = 5;
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;

    localparam int SETTLE_CYCLES    = 200;    // idle time after each drain
    localparam int HOLD_OFF_CYCLES  = 3000;   // long output stall
    localparam int WATCHDOG_LIMIT   = 20000;  // cycles without any transfer
    localparam int GROUPS_PER_PHASE = 25;
    localparam int RANDOM_PHASES    = 16;
    localparam int STALL_PHASE      = 5;
    localparam int PAUSE_PHASE      = 9;
    localparam int QUIET_FROM       = 13;     // no idling from this phase on

    localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;

    // sample picking styles for one group
    localparam int PICK_ANY      = 0;
    localparam int PICK_WINDOW   = 1;
    localparam int PICK_EXTREME  = 2;
    localparam int PICK_NEAR_LOW = 3;
    localparam int PICK_NEAR_HI  = 4;

    typedef struct packed {
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } t_raw_pair;

    typedef struct packed {
        logic [SCR_W-1:0] x;
        logic [SCR_W-1:0] y;
    } t_coord;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [RAW_W-1:0]  i_cfg_data;

    tsam_smp_if smp ();
    tsam_pos_if pos ();

    touch_sample_average_and_map #(
        .SAMPLE_COUNT  (SAMPLE_COUNT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp),
        .o_pos      (pos),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: own copy of the registers and the accumulators
    t_cfg             cal;
    logic [SUM_W-1:0] acc_x;
    logic [SUM_W-1:0] acc_y;
    logic [CNT_W-1:0] pairs_in_group;

    t_raw_pair pending_pairs [$];   // pairs still to be offered
    t_coord    pending_coords [$];  // coordinates the block owes us

    int  mismatches   = 0;
    int  coords_seen  = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  long_hold    = 0;
    int  stall_reqs   = 0;
    int  stall_served = 0;
    int  idle_cycles  = 0;
    bit  no_idle      = 1'b0;
    t_raw_pair next_pair;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int floor_sub(input int a, input int b);
        return (a > b) ? a - b : 0;
    endfunction

    // clamp into the window, then (avg - low) * full / span; empty window gives 0
    function automatic logic [SCR_W-1:0] window_scale(input logic [RAW_W-1:0] avg,
                                                      input logic [RAW_W-1:0] lo,
                                                      input logic [RAW_W-1:0] hi,
                                                      input logic [SCR_W-1:0] full);
        logic [RAW_W-1:0]        a;
        logic [RAW_W-1:0]        span;
        logic [RAW_W-1:0]        diff;
        logic [RAW_W+SCR_W-1:0]  prod;
        a = avg;
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        span = (hi > lo) ? hi - lo : '0;
        if (span == '0) return '0;
        diff = (a > lo) ? a - lo : '0;
        prod = (RAW_W+SCR_W)'(diff) * (RAW_W+SCR_W)'(full);
        return SCR_W'(prod / span);
    endfunction

    function automatic void reset_predictor();
        cal.x_low      = '0;
        cal.x_high     = 16'hFFFF;
        cal.y_low      = '0;
        cal.y_high     = 16'hFFFF;
        cal.scale_y    = 10'd480;
        cal.scale_x    = 10'd320;
        cal.orient     = ORIENT_LAND;
        acc_x          = '0;
        acc_y          = '0;
        pairs_in_group = '0;
    endfunction

    function automatic void apply_reg(input logic [CIDX_W-1:0] idx,
                                      input logic [RAW_W-1:0] data);
        case (idx)
            REG_X_LOW:   cal.x_low   = data;
            REG_X_HIGH:  cal.x_high  = data;
            REG_Y_LOW:   cal.y_low   = data;
            REG_Y_HIGH:  cal.y_high  = data;
            REG_SCALE_Y: cal.scale_y = data[SCR_W-1:0];
            REG_SCALE_X: cal.scale_x = data[SCR_W-1:0];
            REG_ORIENT:  cal.orient  = data[1:0];
            default: ;
        endcase
    endfunction

    // Accumulate one accepted pair; the last of a group yields one coordinate
    function automatic void accumulate_pair(input logic [RAW_W-1:0] sx,
                                            input logic [RAW_W-1:0] sy);
        logic [RAW_W-1:0] avg_x;
        logic [RAW_W-1:0] avg_y;
        logic [SCR_W-1:0] tx;
        logic [SCR_W-1:0] ty;
        int               px;
        int               py;
        t_coord           c;
        acc_x = acc_x + SUM_W'(sx);
        acc_y = acc_y + SUM_W'(sy);
        pairs_in_group = pairs_in_group + 1'b1;
        if (pairs_in_group < SAMPLE_COUNT) return;
        avg_x = RAW_W'(acc_x / SAMPLE_COUNT);
        avg_y = RAW_W'(acc_y / SAMPLE_COUNT);
        tx = window_scale(avg_x, cal.x_low, cal.x_high, cal.scale_y);
        ty = window_scale(avg_y, cal.y_low, cal.y_high, cal.scale_x);
        acc_x = '0;
        acc_y = '0;
        pairs_in_group = '0;
        case (cal.orient)
            ORIENT_LAND: begin
                px = ty;
                py = floor_sub(SCREEN_HEIGHT, tx);
            end
            ORIENT_PORT: begin
                px = tx;
                py = ty;
            end
            ORIENT_PORT_MIR: begin
                px = floor_sub(SCREEN_WIDTH, tx);
                py = floor_sub(SCREEN_HEIGHT, ty);
            end
            default: begin
                px = floor_sub(SCREEN_HEIGHT, ty);
                py = tx;
            end
        endcase
        c.x = px[SCR_W-1:0];
        c.y = py[SCR_W-1:0];
        pending_coords.push_back(c);
    endfunction

    task automatic check_coord(input logic [SCR_W-1:0] x, input logic [SCR_W-1:0] y);
        t_coord want;
        coords_seen++;
        if (pending_coords.size() == 0) begin
            report_mismatch($sformatf("coordinate %0d (%0d,%0d) with none expected",
                                      coords_seen, x, y));
        end else begin
            want = pending_coords.pop_front();
            if (x !== want.x)
                report_mismatch($sformatf("coordinate %0d screen_x %0d, expected %0d",
                                          coords_seen, x, want.x));
            if (y !== want.y)
                report_mismatch($sformatf("coordinate %0d screen_y %0d, expected %0d",
                                          coords_seen, y, want.y));
        end
    endtask

    // Sample driver: one pair held on the channel until its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
            send_gap  <= 0;
        end else begin
            if (smp.valid && smp.ready)
                accumulate_pair(smp.sample_x, smp.sample_y);
            if (smp.valid && !smp.ready) begin
                // hold the pair until it is taken
            end else if (send_gap != 0) begin
                smp.valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (pending_pairs.size() != 0) begin
                next_pair     = pending_pairs.pop_front();
                smp.valid    <= 1'b1;
                smp.sample_x <= next_pair.x;
                smp.sample_y <= next_pair.y;
                if (!no_idle && $urandom_range(0, 15) == 0)
                    send_gap <= $urandom_range(1, 17);
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // Coordinate monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos.ready <= 1'b0;
        end else begin
            if (pos.valid && pos.ready)
                check_coord(pos.screen_x, pos.screen_y);
            if (long_hold != 0) begin
                pos.ready <= 1'b0;
                long_hold <= long_hold - 1;
            end else if (stall_served != stall_reqs) begin
                // long hold-off: the block fills up and stalls its input
                stall_served <= stall_reqs;
                long_hold    <= HOLD_OFF_CYCLES;
                pos.ready    <= 1'b0;
            end else if (recv_gap != 0) begin
                pos.ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end else begin
                pos.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 17);
            end
        end
    end

    // Watchdog: too long with no transfer anywhere ends the run
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (pos.valid && pos.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog expired", $realtime);
                $display("touch_sample_average_and_map test failed");
                $finish;
            end
        end
    end

    // Register write, called just after a rising edge; returns at the next one
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [RAW_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_cal(input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] xh,
                             input logic [RAW_W-1:0] yl, input logic [RAW_W-1:0] yh,
                             input logic [RAW_W-1:0] sy, input logic [RAW_W-1:0] sx,
                             input logic [RAW_W-1:0] orient, input bit poke_unused);
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_ORIENT, orient);
        if (poke_unused)
            write_reg(REG_UNUSED, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] orient_for(input int n);
        case (n % 4)
            0:       return ORIENT_LAND;
            1:       return ORIENT_PORT;
            2:       return ORIENT_PORT_MIR;
            default: return ORIENT_LAND_MIR;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo,
                                                  input logic [RAW_W-1:0] hi,
                                                  input int style);
        int v;
        case (style)
            PICK_WINDOW:   v = $urandom_range(int'(hi), int'(lo));
            PICK_EXTREME:  v = $urandom_range(0, 1) ? 65535 : 0;
            PICK_NEAR_LOW: v = int'(lo) + int'($urandom_range(0, 16)) - 8;
            PICK_NEAR_HI:  v = int'(hi) + int'($urandom_range(0, 16)) - 8;
            default:       v = $urandom_range(0, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return RAW_W'(v);
    endfunction

    function automatic logic [RAW_W-1:0] pick_scale();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'd1023;
            2:       return 16'($urandom);   // upper bits must be dropped
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic pick_window(output logic [RAW_W-1:0] lo, output logic [RAW_W-1:0] hi);
        logic [RAW_W-1:0] a;
        logic [RAW_W-1:0] b;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                lo = '0;
                hi = 16'hFFFF;
            end
            1: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            2: begin
                // zero span
                lo = a;
                hi = a;
            end
            3: begin
                // inverted window
                if (a == b) b = a ^ 16'd1;
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            4: begin
                lo = a;
                hi = (a > 16'hFFC0) ? 16'hFFFF : a + 16'($urandom_range(1, 63));
            end
            default: begin
                lo = a;
                hi = b;
            end
        endcase
    endtask

    task automatic queue_pairs(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                               input int n);
        t_raw_pair p;
        p.x = x;
        p.y = y;
        repeat (n) pending_pairs.push_back(p);
    endtask

    task automatic queue_group(input int style_x, input int style_y);
        t_raw_pair p;
        repeat (SAMPLE_COUNT) begin
            p.x = pick_raw(cal.x_low, cal.x_high, style_x);
            p.y = pick_raw(cal.y_low, cal.y_high, style_y);
            pending_pairs.push_back(p);
        end
    endtask

    // Sender stays quiet until every owed coordinate has arrived
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || smp.valid || pending_coords.size() != 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [RAW_W-1:0] xl;
        logic [RAW_W-1:0] xh;
        logic [RAW_W-1:0] yl;
        logic [RAW_W-1:0] yh;
        int               ph;
        int               g;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        smp.valid    = 1'b0;
        smp.sample_x = '0;
        smp.sample_y = '0;
        pos.ready    = 1'b0;
        reset_predictor();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset calibration, all-zero and all-ones groups
        @(negedge i_clk);
        queue_pairs(16'h0000, 16'h0000, SAMPLE_COUNT);
        queue_pairs(16'hFFFF, 16'hFFFF, SAMPLE_COUNT);
        settle();

        // Directed: narrow window, full scale, averages clamped low and high
        write_cal(16'd1000, 16'd60000, 16'd2000, 16'd50000, 16'hFFFF, 16'd1023,
                  {14'h3FFF, ORIENT_PORT}, 1'b1);
        @(negedge i_clk);
        queue_pairs(16'h0000, 16'h0000, SAMPLE_COUNT);
        queue_pairs(16'hFFFF, 16'hFFFF, SAMPLE_COUNT);
        settle();

        // Directed: zero span on X, inverted window on Y, mirrored portrait
        write_cal(16'd500, 16'd500, 16'd40000, 16'd100, 16'd1023, 16'd1023,
                  {14'h0, ORIENT_PORT_MIR}, 1'b0);
        @(negedge i_clk);
        queue_pairs(16'd1234, 16'd45678, 2);
        queue_pairs(16'd500, 16'd100, 2);
        queue_pairs(16'hFFFF, 16'h0000, 1);
        settle();

        // Random phases, each with a fresh calibration
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_window(xl, xh);
            pick_window(yl, yh);
            write_cal(xl, xh, yl, yh, pick_scale(), pick_scale(),
                      {14'($urandom), orient_for(ph)}, $urandom_range(0, 3) == 0);
            if (ph == STALL_PHASE)
                stall_reqs <= stall_reqs + 1;
            if (ph == QUIET_FROM)
                no_idle <= 1'b1;
            @(negedge i_clk);
            for (g = 0; g < GROUPS_PER_PHASE; g++) begin
                if (ph == PAUSE_PHASE && g == GROUPS_PER_PHASE / 2)
                    wait_drained();
                queue_group($urandom_range(PICK_ANY, PICK_NEAR_HI),
                            $urandom_range(PICK_ANY, PICK_NEAR_HI));
            end
            settle();
        end

        if (pending_coords.size() != 0)
            report_mismatch($sformatf("%0d coordinates never arrived",
                                      pending_coords.size()));
        if (mismatches == 0) begin
            $display("touch_sample_average_and_map test passed");
        end else begin
            $display("touch_sample_average_and_map test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/tsam_pkg.sv
sv/tsam_smp_if.sv
sv/tsam_pos_if.sv
sv/tsam_cfg.sv
sv/tsam_div.sv
sv/touch_sample_average_and_map.sv
dv/testbench.sv
